@@ rtl/core/usbcep_pkg.sv @@
// ----------------------------------------------------------------------------
// usbcep_pkg
// Shared codes and helpers for the endpoint-zero control stage machine.
// ----------------------------------------------------------------------------
`default_nettype none

package usbcep_pkg;

  localparam int CmdW   = 2;
  localparam int StageW = 3;
  localparam int PktW   = 7;
  localparam int CountW = 16;

  localparam logic [CmdW-1:0] CMD_BUS_RESET  = 2'd0;
  localparam logic [CmdW-1:0] CMD_SETUP      = 2'd1;
  localparam logic [CmdW-1:0] CMD_IN_DONE    = 2'd2;
  localparam logic [CmdW-1:0] CMD_OUT_STATUS = 2'd3;

  localparam logic [StageW-1:0] ST_SETUP      = 3'd0;
  localparam logic [StageW-1:0] ST_DATA_IN    = 3'd1;
  localparam logic [StageW-1:0] ST_DATA_IDLE  = 3'd2;
  localparam logic [StageW-1:0] ST_ZERO       = 3'd3;
  localparam logic [StageW-1:0] ST_STATUS_OUT = 3'd4;

  localparam logic [PktW-1:0] MIN_PACKET   = 7'd8;
  localparam logic [PktW-1:0] MAX_PACKET   = 7'd64;
  localparam logic [PktW-1:0] RESET_PACKET = 7'd64;

  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] DESC_DEVICE        = 8'd1;

  localparam int InDataW  = 48;
  localparam int OutDataW = 32;

  function automatic logic [PktW-1:0] packet_limit(input logic [PktW-1:0] mps);
    logic [PktW-1:0] m;
    m = mps;
    if (m < MIN_PACKET) m = MIN_PACKET;
    if (m > MAX_PACKET) m = MAX_PACKET;
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/usb_control_endpoint_stage_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// usb_control_endpoint_stage_fsm_unit
// Endpoint-zero control transfer stage machine with stream ports.
// ----------------------------------------------------------------------------
// Each event transaction (bus reset, setup, IN complete, OUT status) yields
// exactly one result transaction, registered on acceptance. An event is
// taken every cycle while the result register is empty or being drained;
// the single result register sets the throughput of one event per cycle.
// Only a standard GET_DESCRIPTOR for the device descriptor is served, in
// chunks of min(bytes left, max packet size) with a trailing zero-length
// packet after an exact full final chunk. Write max_packet_size only while
// idle; values below 8 act as 8, above 64 as 64.
`default_nettype none

module usb_control_endpoint_stage_fsm_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [usbcep_pkg::PktW-1:0]    cfg_wr_data,   // max_packet_size
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] request_type, [15:8] request_code, [31:16] request_value,
  // [47:32] request_length
  input  wire logic [usbcep_pkg::InDataW-1:0] s_axis_tdata,
  input  wire logic [usbcep_pkg::CmdW-1:0]    s_axis_tuser,  // [1:0] cmd
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [15:0] packet_offset, [22:16] packet_length, [25:23] stage_now,
  // [26] address_cleared, [27] request_handled, [31:28] zero
  output logic [usbcep_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser   // [0] send_packet
);
  import usbcep_pkg::*;

  logic [PktW-1:0]   max_packet_size;
  logic [StageW-1:0] stage;
  logic [CountW-1:0] bytes_left;
  logic [CountW-1:0] send_offset;

  logic [StageW-1:0] stage_next;
  logic [CountW-1:0] bytes_left_next;
  logic [CountW-1:0] send_offset_next;

  logic [CmdW-1:0]   cmd;
  logic [7:0]        rtype;
  logic [7:0]        rcode;
  logic [15:0]       rvalue;
  logic [15:0]       rlength;
  logic              served;

  logic [PktW-1:0]   limit;
  logic [CountW-1:0] base_left;
  logic [CountW-1:0] base_off;
  logic [PktW-1:0]   chunk;
  logic [CountW-1:0] chunk_left;
  logic [CountW-1:0] chunk_off;
  logic [StageW-1:0] chunk_stage;

  logic              r_send;
  logic [CountW-1:0] r_offset;
  logic [PktW-1:0]   r_length;
  logic              r_clear;
  logic              r_handled;

  logic              accept;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd     = s_axis_tuser;
  assign rtype   = s_axis_tdata[7:0];
  assign rcode   = s_axis_tdata[15:8];
  assign rvalue  = s_axis_tdata[31:16];
  assign rlength = s_axis_tdata[47:32];

  assign served = (rtype[6:0] == 7'd0) && (rcode == REQ_GET_DESCRIPTOR) &&
                  (rvalue[15:8] == DESC_DEVICE);

  assign limit     = packet_limit(max_packet_size);
  assign base_left = (cmd == CMD_SETUP) ? rlength : bytes_left;
  assign base_off  = (cmd == CMD_SETUP) ? '0 : send_offset;

  always_comb begin
    if (base_left < {{(CountW-PktW){1'b0}}, limit}) begin
      chunk = base_left[PktW-1:0];
    end else begin
      chunk = limit;
    end
    chunk_left = base_left - {{(CountW-PktW){1'b0}}, chunk};
    chunk_off  = base_off + {{(CountW-PktW){1'b0}}, chunk};
    if (chunk_left != '0) begin
      chunk_stage = ST_DATA_IDLE;
    end else if (chunk == limit) begin
      chunk_stage = ST_ZERO;
    end else begin
      chunk_stage = ST_STATUS_OUT;
    end
  end

  always_comb begin
    stage_next       = stage;
    bytes_left_next  = bytes_left;
    send_offset_next = send_offset;
    r_send           = 1'b0;
    r_offset         = '0;
    r_length         = '0;
    r_clear          = 1'b0;
    r_handled        = 1'b0;
    case (cmd)
      CMD_BUS_RESET: begin
        stage_next       = ST_SETUP;
        bytes_left_next  = '0;
        send_offset_next = '0;
        r_clear          = 1'b1;
      end
      CMD_SETUP: begin
        if (served) begin
          stage_next       = chunk_stage;
          bytes_left_next  = chunk_left;
          send_offset_next = chunk_off;
          r_send           = 1'b1;
          r_offset         = base_off;
          r_length         = chunk;
          r_handled        = 1'b1;
        end else begin
          stage_next       = ST_SETUP;
          bytes_left_next  = '0;
          send_offset_next = '0;
        end
      end
      CMD_IN_DONE: begin
        if (bytes_left != '0) begin
          stage_next       = chunk_stage;
          bytes_left_next  = chunk_left;
          send_offset_next = chunk_off;
          r_send           = 1'b1;
          r_offset         = base_off;
          r_length         = chunk;
        end else if (stage == ST_ZERO) begin
          stage_next = ST_STATUS_OUT;
          r_send     = 1'b1;
          r_offset   = send_offset;
        end
      end
      CMD_OUT_STATUS: begin
        if (stage == ST_STATUS_OUT) begin
          stage_next = ST_SETUP;
        end
      end
      default: begin
        stage_next = stage;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_size <= RESET_PACKET;
      stage           <= ST_SETUP;
      bytes_left      <= '0;
      send_offset     <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_packet_size <= cfg_wr_data;
      end
      if (accept) begin
        stage         <= stage_next;
        bytes_left    <= bytes_left_next;
        send_offset   <= send_offset_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser <= r_send;
      m_axis_tdata <= {4'd0, r_handled, r_clear, stage_next, r_length, r_offset};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/usbcep_checker.sv @@
// ----------------------------------------------------------------------------
// usbcep_props
// Port-level checks for the endpoint-zero control stage machine.
// ----------------------------------------------------------------------------
`default_nettype none

module usbcep_props (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [usbcep_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser
);
  import usbcep_pkg::*;

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  a_no_packet_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[22:0] == 23'd0)
    else $error("offset or length set without a packet");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[22:16] <= MAX_PACKET)
    else $error("packet length above maximum");

  a_reset_event: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[26] |->
      !m_axis_tuser && m_axis_tdata[25:23] == ST_SETUP && !m_axis_tdata[27])
    else $error("bus reset result is inconsistent");

  a_handled_sends: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[27] |->
      m_axis_tuser && m_axis_tdata[15:0] == 16'd0 &&
      (m_axis_tdata[25:23] == ST_DATA_IDLE || m_axis_tdata[25:23] == ST_ZERO ||
       m_axis_tdata[25:23] == ST_STATUS_OUT))
    else $error("served setup did not start a data stage");

endmodule

bind usb_control_endpoint_stage_fsm_unit usbcep_props u_usbcep_props (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
